[rtl/differential_drive_odometry_macros.svh]
// Assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication.
`define ODO_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("odometry check failed");

// Next-cycle implication.
`define ODO_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("odometry check failed");

`endif

[rtl/odo_pkg.sv]
// Types, constants and tables for the odometry block.
package odo_pkg;

	localparam int CNT_W  = 32;
	localparam int POS_W  = 40;
	localparam int HEAD_W = 32;
	localparam int MM_W   = 16;
	localparam int INV_W  = 24;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_STEP     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_TRACK_WIDTH = 8'd1;
	localparam logic [MM_W-1:0]  MM_RESET  = 16'd8520;
	localparam logic [INV_W-1:0] INV_RESET = 24'd316551;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int ITER_W = $clog2(ATAN_ENTRIES);

	localparam int ANG_W = 33;
	localparam int Z_W   = 34;
	localparam int XY_W  = 34;
	localparam int CS_W  = XY_W - 8;
	localparam int ATAN_W = 30;

	localparam logic signed [ANG_W-1:0] PI_Q27      = 33'sd421657428;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q27  = 33'sd843314857;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q27 = 33'sd210828714;
	localparam logic signed [Z_W-1:0]   Z_HALF_PI   = 34'sd1686629712;
	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

	localparam int SPLIT  = 16;
	localparam int MA_W   = 25;
	localparam int MB_W   = 26;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 66;
	localparam int DR_W   = 48;

	typedef struct packed {
		logic signed [CNT_W-1:0] right_count;
		logic signed [CNT_W-1:0] left_count;
		logic                    clear;
	} odo_tick_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [HEAD_W-1:0] heading;
	} odo_pose_t;

	function automatic logic [ATAN_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
		case (idx)
			5'd0:    return 30'h3243F6A8;
			5'd1:    return 30'h1DAC6705;
			5'd2:    return 30'h0FADBAFC;
			5'd3:    return 30'h07F56EA6;
			5'd4:    return 30'h03FEAB76;
			5'd5:    return 30'h01FFD55B;
			5'd6:    return 30'h00FFFAAA;
			5'd7:    return 30'h007FFF55;
			5'd8:    return 30'h003FFFEA;
			5'd9:    return 30'h001FFFFD;
			5'd10:   return 30'h000FFFFF;
			5'd11:   return 30'h0007FFFF;
			5'd12:   return 30'h0003FFFF;
			5'd13:   return 30'h0001FFFF;
			5'd14:   return 30'h0000FFFF;
			5'd15:   return 30'h00007FFF;
			5'd16:   return 30'h00003FFF;
			5'd17:   return 30'h00001FFF;
			5'd18:   return 30'h00000FFF;
			5'd19:   return 30'h000007FF;
			5'd20:   return 30'h000003FF;
			5'd21:   return 30'h000001FF;
			5'd22:   return 30'h000000FF;
			5'd23:   return 30'h0000007F;
			default: return '0;
		endcase
	endfunction

endpackage

[rtl/differential_drive_odometry.sv]
// Differential-drive odometry: encoder deltas to pose with a shared multiplier and CORDIC.
//
// Channel  Handshake              Payload
// tick     tick_valid/tick_stall  odo_tick_t: right_count, left_count, clear
// pose     pose_valid/pose_stall  odo_pose_t: pos_x, pos_y, heading
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An item goes from accept to the pose register through the DR and DL multiplies, the
// mean/difference step, the wrap of the heading into [-pi, pi], CORDIC_ITERS CORDIC steps
// and the MX, MY and MT multiplies: five split 25x26 multiplies in phases LO, HI, ADD, RET.
// The next tick is taken the cycle after the pose register loads; it is not held up by a
// stalled pose item unless the following update is ready first.
// Reset zeroes the internal pose and previous counts and restores the register defaults.
`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  tick_valid,
	output logic                                  tick_stall,
	input  odo_pkg::odo_tick_t                    tick,
	output logic                                  pose_valid,
	input  logic                                  pose_stall,
	output odo_pkg::odo_pose_t                    pose,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [odo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [odo_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_MD   = 3'd2;
	localparam logic [2:0] ST_RED  = 3'd3;
	localparam logic [2:0] ST_ROT  = 3'd4;
	localparam logic [2:0] ST_CS   = 3'd5;
	localparam logic [2:0] ST_UPD  = 3'd6;

	localparam logic [2:0] OP_DR = 3'd0;
	localparam logic [2:0] OP_DL = 3'd1;
	localparam logic [2:0] OP_MX = 3'd2;
	localparam logic [2:0] OP_MY = 3'd3;
	localparam logic [2:0] OP_MT = 3'd4;

	localparam logic [1:0] PH_LO  = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_ADD = 2'd2;
	localparam logic [1:0] PH_RET = 2'd3;

	localparam logic signed [47:0] MEAN_MAX = 48'sd549755813887;
	localparam logic signed [47:0] MEAN_MIN = -48'sd549755813888;
	localparam logic signed [48:0] DIFF_LIM = 49'sd274877906944;
	localparam logic signed [44:0] POS_MAX  = 45'sd549755813887;
	localparam logic signed [44:0] POS_MIN  = -45'sd549755813888;
	localparam logic signed [52:0] DTH_LIM  = 53'sd4294967296;
	localparam logic signed [34:0] HEAD_MAX = 35'sd2147483647;
	localparam logic signed [34:0] HEAD_MIN = -35'sd2147483648;

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [1:0] ph_q;
	logic [odo_pkg::ITER_W-1:0] iter_q;
	logic pose_valid_q;
	odo_pkg::odo_pose_t out_q;

	logic [odo_pkg::MM_W-1:0]  mm_q;
	logic [odo_pkg::INV_W-1:0] inv_q;
	logic signed [odo_pkg::POS_W-1:0]  pose_x_q, pose_y_q;
	logic signed [odo_pkg::HEAD_W-1:0] pose_h_q;
	logic signed [odo_pkg::CNT_W-1:0]  last_r_q, last_l_q;

	logic signed [odo_pkg::CNT_W-1:0]  delta_r_q, delta_l_q;
	logic clear_q;
	logic signed [odo_pkg::DR_W-1:0]   dr_q, dl_q;
	logic signed [odo_pkg::POS_W-1:0]  mean_q, diff_q;
	logic signed [odo_pkg::PROD_W-1:0] prod_q;
	logic signed [odo_pkg::ACC_W-1:0]  acc_q;
	logic signed [odo_pkg::ANG_W-1:0]  a_q;
	logic flip_q;
	logic signed [odo_pkg::Z_W-1:0]    z_q;
	logic signed [odo_pkg::XY_W-1:0]   x_q, y_q;
	logic signed [odo_pkg::CS_W-1:0]   c_q, s_q;
	logic signed [odo_pkg::POS_W-1:0]  nx_q, ny_q;
	logic signed [odo_pkg::HEAD_W-1:0] hs_q;

	logic tick_acc;
	logic upd_go;

	logic signed [odo_pkg::POS_W-1:0]  src_a;
	logic signed [odo_pkg::MB_W-1:0]   src_b;
	logic signed [odo_pkg::MA_W-1:0]   mul_a;
	logic signed [odo_pkg::PROD_W-1:0] mul_p;
	logic signed [odo_pkg::ACC_W-1:0]  acc_sum;

	logic signed [48:0] md_sum, md_diff;
	logic signed [47:0] md_half;
	logic signed [odo_pkg::POS_W-1:0] mean_n, diff_n;

	logic signed [43:0] dxy;
	logic signed [44:0] pos_sum;
	logic signed [odo_pkg::POS_W-1:0] pos_n;
	logic signed [52:0] dth_raw;
	logic signed [33:0] dth;
	logic signed [34:0] h_sum;
	logic signed [odo_pkg::HEAD_W-1:0] h_sat;

	logic signed [odo_pkg::ANG_W-1:0] a_half;
	logic a_flip;
	logic signed [odo_pkg::XY_W-1:0] x_sh, y_sh;
	logic signed [odo_pkg::Z_W-1:0]  atan_z;
	logic signed [odo_pkg::XY_W-1:0] cx, cy;

	logic signed [odo_pkg::ANG_W-1:0] h_ext, h_wrap;

	assign tick_stall = (state_q != ST_IDLE);
	assign tick_acc   = tick_valid && !tick_stall;
	assign cfg_ready  = 1'b1;
	assign upd_go     = !pose_valid_q || !pose_stall;
	assign pose_valid = pose_valid_q;
	assign pose       = out_q;

	always_comb begin
		case (op_q)
			OP_DR:   src_a = {{(odo_pkg::POS_W-odo_pkg::CNT_W){delta_r_q[odo_pkg::CNT_W-1]}}, delta_r_q};
			OP_DL:   src_a = {{(odo_pkg::POS_W-odo_pkg::CNT_W){delta_l_q[odo_pkg::CNT_W-1]}}, delta_l_q};
			OP_MX:   src_a = mean_q;
			OP_MY:   src_a = mean_q;
			OP_MT:   src_a = diff_q;
			default: src_a = '0;
		endcase
		case (op_q)
			OP_DR:   src_b = {{(odo_pkg::MB_W-odo_pkg::MM_W){1'b0}}, mm_q};
			OP_DL:   src_b = {{(odo_pkg::MB_W-odo_pkg::MM_W){1'b0}}, mm_q};
			OP_MX:   src_b = c_q;
			OP_MY:   src_b = s_q;
			OP_MT:   src_b = {{(odo_pkg::MB_W-odo_pkg::INV_W){1'b0}}, inv_q};
			default: src_b = '0;
		endcase
		if (ph_q == PH_LO) begin
			mul_a = {{(odo_pkg::MA_W-odo_pkg::SPLIT){1'b0}}, src_a[odo_pkg::SPLIT-1:0]};
		end else begin
			mul_a = {src_a[odo_pkg::POS_W-1], src_a[odo_pkg::POS_W-1:odo_pkg::SPLIT]};
		end
		mul_p   = mul_a * src_b;
		acc_sum = acc_q + {prod_q[odo_pkg::ACC_W-odo_pkg::SPLIT-1:0], {odo_pkg::SPLIT{1'b0}}};
	end

	always_comb begin
		md_sum  = {dr_q[odo_pkg::DR_W-1], dr_q} + {dl_q[odo_pkg::DR_W-1], dl_q};
		md_diff = {dr_q[odo_pkg::DR_W-1], dr_q} - {dl_q[odo_pkg::DR_W-1], dl_q};
		md_half = md_sum[48:1];
		if (md_half > MEAN_MAX) begin
			mean_n = MEAN_MAX[odo_pkg::POS_W-1:0];
		end else if (md_half < MEAN_MIN) begin
			mean_n = MEAN_MIN[odo_pkg::POS_W-1:0];
		end else begin
			mean_n = md_half[odo_pkg::POS_W-1:0];
		end
		if (md_diff > DIFF_LIM) begin
			diff_n = DIFF_LIM[odo_pkg::POS_W-1:0];
		end else if (md_diff < -DIFF_LIM) begin
			diff_n = -DIFF_LIM[odo_pkg::POS_W-1:0];
		end else begin
			diff_n = md_diff[odo_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		dxy = acc_q[odo_pkg::ACC_W-1:22];
		if (op_q == OP_MX) begin
			pos_sum = {{5{pose_x_q[odo_pkg::POS_W-1]}}, pose_x_q} + {dxy[43], dxy};
		end else begin
			pos_sum = {{5{pose_y_q[odo_pkg::POS_W-1]}}, pose_y_q} + {dxy[43], dxy};
		end
		if (pos_sum > POS_MAX) begin
			pos_n = POS_MAX[odo_pkg::POS_W-1:0];
		end else if (pos_sum < POS_MIN) begin
			pos_n = POS_MIN[odo_pkg::POS_W-1:0];
		end else begin
			pos_n = pos_sum[odo_pkg::POS_W-1:0];
		end
		dth_raw = acc_q[odo_pkg::ACC_W-1:13];
		if (dth_raw > DTH_LIM) begin
			dth = DTH_LIM[33:0];
		end else if (dth_raw < -DTH_LIM) begin
			dth = -DTH_LIM[33:0];
		end else begin
			dth = dth_raw[33:0];
		end
		h_sum = {{3{pose_h_q[odo_pkg::HEAD_W-1]}}, pose_h_q} + {dth[33], dth};
		if (h_sum > HEAD_MAX) begin
			h_sat = HEAD_MAX[odo_pkg::HEAD_W-1:0];
		end else if (h_sum < HEAD_MIN) begin
			h_sat = HEAD_MIN[odo_pkg::HEAD_W-1:0];
		end else begin
			h_sat = h_sum[odo_pkg::HEAD_W-1:0];
		end
	end

	always_comb begin
		if (a_q > odo_pkg::HALF_PI_Q27) begin
			a_half = a_q - odo_pkg::PI_Q27;
			a_flip = 1'b1;
		end else if (a_q < -odo_pkg::HALF_PI_Q27) begin
			a_half = a_q + odo_pkg::PI_Q27;
			a_flip = 1'b1;
		end else begin
			a_half = a_q;
			a_flip = 1'b0;
		end
		x_sh   = x_q >>> iter_q;
		y_sh   = y_q >>> iter_q;
		atan_z = {{(odo_pkg::Z_W-odo_pkg::ATAN_W){1'b0}}, odo_pkg::atan_q30(iter_q)};
		cx     = flip_q ? -x_q : x_q;
		cy     = flip_q ? -y_q : y_q;
		h_ext  = {hs_q[odo_pkg::HEAD_W-1], hs_q};
		if (h_ext > odo_pkg::TWO_PI_Q27) begin
			h_wrap = h_ext - odo_pkg::TWO_PI_Q27;
		end else if (h_ext < -odo_pkg::TWO_PI_Q27) begin
			h_wrap = h_ext + odo_pkg::TWO_PI_Q27;
		end else begin
			h_wrap = h_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_DR;
			ph_q         <= PH_LO;
			iter_q       <= '0;
			pose_valid_q <= 1'b0;
			mm_q         <= odo_pkg::MM_RESET;
			inv_q        <= odo_pkg::INV_RESET;
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			pose_h_q     <= '0;
			last_r_q     <= '0;
			last_l_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == odo_pkg::CFG_MM_PER_STEP) begin
					mm_q <= cfg_data[odo_pkg::MM_W-1:0];
				end else if (cfg_index == odo_pkg::CFG_INV_TRACK_WIDTH) begin
					inv_q <= cfg_data[odo_pkg::INV_W-1:0];
				end
			end
			if (state_q == ST_UPD && upd_go) begin
				pose_valid_q <= 1'b1;
			end else if (!pose_stall) begin
				pose_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						last_r_q <= tick.right_count;
						last_l_q <= tick.left_count;
						op_q     <= OP_DR;
						ph_q     <= PH_LO;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == PH_RET) begin
						case (op_q)
							OP_DR:   op_q <= OP_DL;
							OP_DL:   state_q <= ST_MD;
							OP_MX:   op_q <= OP_MY;
							OP_MY:   op_q <= OP_MT;
							OP_MT:   state_q <= ST_UPD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MD: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (!(a_q > odo_pkg::PI_Q27) && !(a_q < -odo_pkg::PI_Q27)) begin
						iter_q  <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == odo_pkg::ITER_W'(odo_pkg::CORDIC_ITERS - 1)) begin
						state_q <= ST_CS;
					end
				end
				ST_CS: begin
					op_q    <= OP_MX;
					ph_q    <= PH_LO;
					state_q <= ST_MUL;
				end
				ST_UPD: begin
					if (upd_go) begin
						if (clear_q) begin
							pose_x_q <= '0;
							pose_y_q <= '0;
							pose_h_q <= '0;
						end else begin
							pose_x_q <= nx_q;
							pose_y_q <= ny_q;
							pose_h_q <= h_wrap[odo_pkg::HEAD_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			delta_r_q <= tick.right_count - last_r_q;
			delta_l_q <= tick.left_count - last_l_q;
			clear_q   <= tick.clear;
		end
		if (state_q == ST_MUL) begin
			case (ph_q)
				PH_LO: prod_q <= mul_p;
				PH_HI: begin
					acc_q  <= {{(odo_pkg::ACC_W-odo_pkg::PROD_W){prod_q[odo_pkg::PROD_W-1]}}, prod_q};
					prod_q <= mul_p;
				end
				PH_ADD: acc_q <= acc_sum;
				PH_RET: begin
					case (op_q)
						OP_DR:   dr_q <= acc_q[odo_pkg::DR_W-1:0];
						OP_DL:   dl_q <= acc_q[odo_pkg::DR_W-1:0];
						OP_MX:   nx_q <= pos_n;
						OP_MY:   ny_q <= pos_n;
						OP_MT:   hs_q <= h_sat;
						default: hs_q <= h_sat;
					endcase
				end
				default: prod_q <= mul_p;
			endcase
		end
		if (state_q == ST_MD) begin
			mean_q <= mean_n;
			diff_q <= diff_n;
			a_q    <= {pose_h_q[odo_pkg::HEAD_W-1], pose_h_q};
		end
		if (state_q == ST_RED) begin
			if (a_q > odo_pkg::PI_Q27) begin
				a_q <= a_q - odo_pkg::TWO_PI_Q27;
			end else if (a_q < -odo_pkg::PI_Q27) begin
				a_q <= a_q + odo_pkg::TWO_PI_Q27;
			end else begin
				flip_q <= a_flip;
				z_q    <= {a_half[odo_pkg::Z_W-4:0], 3'b000};
				x_q    <= odo_pkg::CORDIC_GAIN;
				y_q    <= '0;
			end
		end
		if (state_q == ST_ROT) begin
			if (!z_q[odo_pkg::Z_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_z;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_z;
			end
		end
		if (state_q == ST_CS) begin
			c_q <= cx[odo_pkg::XY_W-1:8];
			s_q <= cy[odo_pkg::XY_W-1:8];
		end
		if (state_q == ST_UPD && upd_go) begin
			if (clear_q) begin
				out_q <= '0;
			end else begin
				out_q.pos_x   <= nx_q;
				out_q.pos_y   <= ny_q;
				out_q.heading <= h_wrap[odo_pkg::HEAD_W-1:0];
			end
		end
	end

	`ODO_ASSERT_NEXT(a_accept_starts_mul, clk, arst_n, tick_acc, (state_q == ST_MUL) && (ph_q == PH_LO) && (op_q == OP_DR))
	`ODO_ASSERT_IMP(a_rot_iter_range, clk, arst_n, state_q == ST_ROT, iter_q < odo_pkg::ITER_W'(odo_pkg::CORDIC_ITERS))
	`ODO_ASSERT_IMP(a_rot_start_range, clk, arst_n, (state_q == ST_ROT) && (iter_q == '0), (z_q <= odo_pkg::Z_HALF_PI) && (z_q >= -odo_pkg::Z_HALF_PI))
	`ODO_ASSERT_NEXT(a_upd_loads_pose, clk, arst_n, (state_q == ST_UPD) && upd_go, pose_valid && (state_q == ST_IDLE))

endmodule

[bench/odo_pose_check_pkg.sv]
// Pose tracker for the odometry bench: predicts each pose item and checks the block's results.
package odo_pose_check_pkg;
	import odo_pkg::*;

	localparam longint ANG_PI      = 64'sd421657428;
	localparam longint ANG_TWO_PI  = 64'sd843314857;
	localparam longint ANG_HALF_PI = 64'sd210828714;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint POS_MAX     = 64'sd549755813887;
	localparam longint POS_MIN     = -64'sd549755813888;
	localparam longint DIFF_LIM    = 64'sd274877906944;
	localparam longint DTH_LIM     = 64'sd4294967296;
	localparam longint HEAD_MAX    = 64'sd2147483647;
	localparam longint HEAD_MIN    = -64'sd2147483648;
	localparam int     SINCOS_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam longint ATAN_TAB [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	class pose_scoreboard;
		bit [MM_W-1:0]       step_len;
		bit [INV_W-1:0]      inv_track;
		longint              x_mm;
		longint              y_mm;
		longint              head;
		logic signed [31:0]  prev_right;
		logic signed [31:0]  prev_left;
		odo_pose_t           expected_poses[$];
		int                  mismatches;
		int                  results_seen;

		function new();
			step_len     = MM_RESET;
			inv_track    = INV_RESET;
			x_mm         = 0;
			y_mm         = 0;
			head         = 0;
			prev_right   = '0;
			prev_left    = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_MM_PER_STEP) begin
				step_len = data[MM_W-1:0];
			end else if (idx == CFG_INV_TRACK_WIDTH) begin
				inv_track = data[INV_W-1:0];
			end
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void heading_sincos(longint h, output longint c, output longint s);
			longint a;
			longint x;
			longint y;
			longint z;
			longint nx;
			bit     flip;
			a = h;
			x = GAIN_Q30;
			y = 0;
			flip = 1'b0;
			while (a > ANG_PI)
				a -= ANG_TWO_PI;
			while (a < -ANG_PI)
				a += ANG_TWO_PI;
			if (a > ANG_HALF_PI) begin
				a -= ANG_PI;
				flip = 1'b1;
			end else if (a < -ANG_HALF_PI) begin
				a += ANG_PI;
				flip = 1'b1;
			end
			z = a * 8;
			for (int i = 0; i < SINCOS_ITERS; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= ATAN_TAB[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += ATAN_TAB[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_tick(odo_tick_t t);
			logic signed [31:0] dr_steps;
			logic signed [31:0] dl_steps;
			longint             dr;
			longint             dl;
			longint             mean;
			longint             diff;
			longint             c;
			longint             s;
			longint             dth;
			longint             h;
			odo_pose_t          p;
			dr_steps = t.right_count - prev_right;
			dl_steps = t.left_count - prev_left;
			prev_right = t.right_count;
			prev_left = t.left_count;
			dr = longint'(dr_steps) * longint'(step_len);
			dl = longint'(dl_steps) * longint'(step_len);
			mean = clamp((dr + dl) >>> 1, POS_MIN, POS_MAX);
			diff = clamp(dr - dl, -DIFF_LIM, DIFF_LIM);
			heading_sincos(head, c, s);
			c = c >>> 8;
			s = s >>> 8;
			x_mm = clamp(x_mm + ((mean * c) >>> 22), POS_MIN, POS_MAX);
			y_mm = clamp(y_mm + ((mean * s) >>> 22), POS_MIN, POS_MAX);
			dth = clamp((diff * longint'(inv_track)) >>> 13, -DTH_LIM, DTH_LIM);
			h = clamp(head + dth, HEAD_MIN, HEAD_MAX);
			if (h > ANG_TWO_PI)
				h -= ANG_TWO_PI;
			else if (h < -ANG_TWO_PI)
				h += ANG_TWO_PI;
			head = h;
			if (t.clear) begin
				x_mm = 0;
				y_mm = 0;
				head = 0;
			end
			p.pos_x = x_mm[POS_W-1:0];
			p.pos_y = y_mm[POS_W-1:0];
			p.heading = head[HEAD_W-1:0];
			expected_poses.push_back(p);
		endfunction

		function void check_pose(odo_pose_t got);
			odo_pose_t want;
			results_seen++;
			if (expected_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose item: x=%h y=%h heading=%h",
						got.pos_x, got.pos_y, got.heading);
				return;
			end
			want = expected_poses.pop_front();
			if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
					got.heading !== want.heading) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pose %0d: expected x=%h y=%h heading=%h, got x=%h y=%h heading=%h",
						results_seen, want.pos_x, want.pos_y, want.heading,
						got.pos_x, got.pos_y, got.heading);
			end
		endfunction

		function int pending();
			return expected_poses.size();
		endfunction
	endclass

endpackage

[bench/tb_top.sv]
// Top-level bench for the odometry block: drives encoder ticks and register writes, checks poses.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import odo_pkg::*;
	import odo_pose_check_pkg::*;

	localparam int LONG_HOLD = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'hA5;

	logic                  clk;
	logic                  arst_n;
	logic                  tick_valid;
	logic                  tick_stall;
	odo_tick_t             tick;
	logic                  pose_valid;
	logic                  pose_stall;
	odo_pose_t             pose;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pose_scoreboard        sb = new();
	bit                    idle_on;
	logic signed [31:0]    cur_r;
	logic signed [31:0]    cur_l;

	differential_drive_odometry u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.pose_valid (pose_valid),
		.pose_stall (pose_stall),
		.pose       (pose),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && pose_valid && !pose_stall)
			sb.check_pose(pose);
	end

	// Receiver: random stall bursts, plus one long hold-off so the block backs up.
	initial begin : pose_sink
		bit held;
		int n;
		held = 1'b0;
		pose_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sb.results_seen >= 60) begin
				held = 1'b1;
				pose_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				pose_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				pose_stall <= 1'b1;
				repeat (n) @(posedge clk);
				pose_stall <= 1'b0;
			end
		end
	end

	task automatic send_counts(input logic signed [31:0] r, input logic signed [31:0] l,
			input bit clr);
		odo_tick_t t;
		t.right_count = r;
		t.left_count = l;
		t.clear = clr;
		cur_r = r;
		cur_l = l;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		tick <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall);
		sb.note_tick(t);
	endtask

	// Mostly smooth wheel motion; some turns, raw noise and counter wrap.
	task automatic run_random(input int count);
		int mode;
		int d;
		bit clr;
		repeat (count) begin
			mode = $urandom_range(0, 99);
			clr = ($urandom_range(0, 19) == 0);
			if (mode < 65) begin
				send_counts(cur_r + ($urandom_range(0, 400) - 200),
					cur_l + ($urandom_range(0, 400) - 200), clr);
			end else if (mode < 80) begin
				d = $urandom_range(0, 3000) - 1500;
				send_counts(cur_r + d, cur_l - d, clr);
			end else if (mode < 92) begin
				send_counts($urandom, $urandom, clr);
			end else if (mode < 96) begin
				send_counts(32'h7FFFFFFF - $urandom_range(0, 3),
					32'h7FFFFFFF - $urandom_range(0, 3), clr);
			end else begin
				send_counts(32'h80000000 + $urandom_range(0, 3),
					32'h80000000 + $urandom_range(0, 3), clr);
			end
		end
	endtask

	task automatic load_regs(input logic [CFG_DATA_W-1:0] mm_word,
			input logic [CFG_DATA_W-1:0] inv_word, input bit with_spare);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		idx[0] = CFG_MM_PER_STEP;
		val[0] = mm_word;
		idx[1] = CFG_SPARE;
		val[1] = CFG_DATA_W'($urandom);
		idx[2] = CFG_INV_TRACK_WIDTH;
		val[2] = inv_word;
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (k != 1 || with_spare) begin
				cfg_index <= idx[k];
				cfg_data <= val[k];
				do @(posedge clk); while (!cfg_ready);
				sb.set_reg(idx[k], val[k]);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] mm_word;
		logic [CFG_DATA_W-1:0] inv_word;
		arst_n = 1'b0;
		tick_valid <= 1'b0;
		tick <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MM_PER_STEP;
		cfg_data <= '0;
		cur_r = '0;
		cur_l = '0;
		idle_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_counts(32'sd0, 32'sd0, 1'b0);
		send_counts(32'sd1000, 32'sd1000, 1'b0);
		send_counts(32'sd1300, 32'sd700, 1'b0);
		send_counts(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
		send_counts(32'h80000000, 32'h80000000, 1'b0);
		send_counts(32'h7FFFFFFF, 32'h80000000, 1'b0);
		send_counts(32'h80000000, 32'h7FFFFFFF, 1'b0);
		send_counts(32'h80000000, 32'h80000000, 1'b1);
		send_counts(32'h80000010, 32'h80000008, 1'b0);
		repeat (6) send_counts(cur_r + 600, cur_l - 600, 1'b0);
		repeat (6) send_counts(cur_r - 700, cur_l + 700, 1'b0);
		send_counts(32'hFFFFFFFF, 32'sd0, 1'b0);
		send_counts(32'sd0, 32'hFFFFFFFF, 1'b0);
		send_counts(cur_r, cur_l, 1'b1);
		run_random(150);
		drain();

		mm_word = {8'($urandom), 16'hFFFF};
		load_regs(mm_word, 24'hFFFFFF, 1'b0);
		run_random(80);
		drain();

		load_regs(24'h0, 24'h0, 1'b1);
		run_random(40);
		drain();

		repeat (3) begin
			mm_word = CFG_DATA_W'($urandom);
			inv_word = CFG_DATA_W'($urandom_range(0, 24'h0FFFFF));
			load_regs(mm_word, inv_word, 1'($urandom_range(0, 1)));
			run_random(50);
			drain();
		end

		idle_on = 1'b0;
		load_regs(24'(MM_RESET), INV_RESET, 1'b0);
		run_random(130);
		drain();
		repeat (60) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
